### hdl/text_console_writer_assert.svh
// Assertion macros shared by the text console checker.
// Depends on nothing; included by files that hold concurrent assertions.
`ifndef TEXT_CONSOLE_WRITER_ASSERT_SVH
`define TEXT_CONSOLE_WRITER_ASSERT_SVH

// Checked on every clock edge outside of reset.
`define TCW_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("text console check failed");

// Checked on every clock edge, reset included.
`define TCW_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("text console reset check failed");

`endif

### hdl/tcw_pkg.sv
// Shared constants, codes and command/status types of the text console writer.
// Depends on nothing; used by all modules of the block.
package tcw_pkg;

    // Screen geometry.
    localparam int COLUMNS = 80;
    localparam int ROWS    = 25;
    localparam int CELLS   = ROWS * COLUMNS;
    localparam int ADDR_W  = $clog2(CELLS);
    localparam int CNT_W   = $clog2(CELLS + 1);

    // Field widths.
    localparam int OP_W   = 2;
    localparam int CHAR_W = 8;
    localparam int COL_W  = 7;
    localparam int ROW_W  = 5;

    // Operation codes.
    localparam logic [OP_W-1:0] OP_PUT    = 2'd0;
    localparam logic [OP_W-1:0] OP_SETCOL = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;
    localparam logic [OP_W-1:0] OP_READ   = 2'd3;

    // Character codes.
    localparam logic [CHAR_W-1:0] CH_NUL   = 8'd0;
    localparam logic [CHAR_W-1:0] CH_LF    = 8'd10;
    localparam logic [CHAR_W-1:0] CH_CR    = 8'd13;
    localparam logic [CHAR_W-1:0] CH_BLANK = 8'h20;

    // Blanking range selection.
    localparam logic [2:0] FILL_NONE = 3'd0;
    localparam logic [2:0] FILL_ALL  = 3'd1;
    localparam logic [2:0] FILL_EOL  = 3'd2;
    localparam logic [2:0] FILL_ROW  = 3'd3;
    localparam logic [2:0] FILL_SET  = 3'd4;
    localparam logic [2:0] FILL_LAST = 3'd5;

    // Cursor update selection.
    localparam logic [2:0] CUR_HOLD     = 3'd0;
    localparam logic [2:0] CUR_HOME     = 3'd1;
    localparam logic [2:0] CUR_LF       = 3'd2;
    localparam logic [2:0] CUR_CR       = 3'd3;
    localparam logic [2:0] CUR_ADV      = 3'd4;
    localparam logic [2:0] CUR_SET      = 3'd5;
    localparam logic [2:0] CUR_SCROLLED = 3'd6;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       cap_in;
        logic [2:0] fill_sel;
        logic       fill_step;
        logic       copy_start;
        logic       copy_step;
        logic       put_wr;
        logic       rd_cell;
        logic       cap_cell;
        logic       clr_cell;
        logic [2:0] cur_sel;
        logic       out_load;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            ch_zero;
        logic            ch_lf;
        logic            ch_cr;
        logic            scroll_pend;
        logic            set_blank;
        logic            rd_ok;
        logic            fill_last;
        logic            copy_done;
        logic            out_free;
    } t_stat;

endpackage

### hdl/tcw_datapath.sv
// Datapath of the text console writer: screen memory, cursor, range counter
// and output register. Depends on tcw_pkg; driven by tcw_ctrl commands.
module tcw_datapath (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic [tcw_pkg::OP_W-1:0]     i_op,
    input  logic [tcw_pkg::CHAR_W-1:0]   i_char_code,
    input  logic [tcw_pkg::COL_W-1:0]    i_column,
    input  logic [tcw_pkg::ROW_W-1:0]    i_row,
    input  tcw_pkg::t_cmd                i_cmd,
    output tcw_pkg::t_stat               o_stat,
    input  logic                         i_out_stall,
    output logic                         o_out_valid,
    output logic [tcw_pkg::COL_W-1:0]    o_cursor_col,
    output logic [tcw_pkg::ROW_W-1:0]    o_cursor_row,
    output logic [tcw_pkg::CHAR_W-1:0]   o_cell_char
);

    localparam logic [tcw_pkg::CNT_W-1:0] CNT_COLS  = tcw_pkg::CNT_W'(tcw_pkg::COLUMNS);
    localparam logic [tcw_pkg::CNT_W-1:0] CNT_CELLS = tcw_pkg::CNT_W'(tcw_pkg::CELLS);
    localparam logic [tcw_pkg::CNT_W-1:0] COPY_LIM  =
        tcw_pkg::CNT_W'(tcw_pkg::CELLS - tcw_pkg::COLUMNS);
    localparam logic [tcw_pkg::COL_W-1:0] COL_LAST  = tcw_pkg::COL_W'(tcw_pkg::COLUMNS - 1);
    localparam logic [tcw_pkg::COL_W-1:0] COL_MAX   = tcw_pkg::COL_W'(tcw_pkg::COLUMNS);
    localparam logic [tcw_pkg::ROW_W-1:0] ROW_MAX   = tcw_pkg::ROW_W'(tcw_pkg::ROWS);
    localparam logic [tcw_pkg::ROW_W-1:0] ROW_LAST  = tcw_pkg::ROW_W'(tcw_pkg::ROWS - 1);

    logic [tcw_pkg::CHAR_W-1:0] r_mem [tcw_pkg::CELLS];

    logic [tcw_pkg::OP_W-1:0]   r_op;
    logic [tcw_pkg::CHAR_W-1:0] r_ch;
    logic [tcw_pkg::COL_W-1:0]  r_col_in;
    logic [tcw_pkg::ROW_W-1:0]  r_row_in;
    logic [tcw_pkg::COL_W-1:0]  r_cur_col, n_cur_col;
    logic [tcw_pkg::ROW_W-1:0]  r_cur_row, n_cur_row;
    logic [tcw_pkg::CNT_W-1:0]  r_addr, n_addr;
    logic [tcw_pkg::CNT_W-1:0]  r_end, n_end;
    logic [tcw_pkg::ADDR_W-1:0] r_cp_addr;
    logic                       r_cp_vld;
    logic [tcw_pkg::CHAR_W-1:0] r_rd_data;
    logic [tcw_pkg::CHAR_W-1:0] r_cell;
    logic                       r_out_vld;
    logic [tcw_pkg::COL_W-1:0]  r_out_col;
    logic [tcw_pkg::ROW_W-1:0]  r_out_row;
    logic [tcw_pkg::CHAR_W-1:0] r_out_cell;

    logic [tcw_pkg::CNT_W-1:0]  w_base;
    logic [tcw_pkg::CNT_W-1:0]  w_cur_addr;
    logic [tcw_pkg::CNT_W-1:0]  w_cell_addr;
    logic [tcw_pkg::COL_W-1:0]  w_set_x;
    logic                       w_copy_issue;
    logic                       w_we;
    logic [tcw_pkg::ADDR_W-1:0] w_wa;
    logic [tcw_pkg::CHAR_W-1:0] w_wd;
    logic                       w_re;
    logic [tcw_pkg::CNT_W-1:0]  w_ra;
    logic                       w_out_free;

    // Address arithmetic for the cursor row and the requested cell.
    assign w_base       = tcw_pkg::CNT_W'(r_cur_row) * CNT_COLS;
    assign w_cur_addr   = w_base + tcw_pkg::CNT_W'(r_cur_col);
    assign w_cell_addr  = tcw_pkg::CNT_W'(r_row_in) * CNT_COLS + tcw_pkg::CNT_W'(r_col_in);
    assign w_set_x      = (r_col_in >= COL_MAX) ? COL_LAST : r_col_in;
    assign w_copy_issue = i_cmd.copy_step && (r_addr < COPY_LIM);
    assign w_out_free   = !r_out_vld || !i_out_stall;

    // Status back to the controller.
    always_comb begin
        o_stat.op          = r_op;
        o_stat.ch_zero     = (r_ch == tcw_pkg::CH_NUL);
        o_stat.ch_lf       = (r_ch == tcw_pkg::CH_LF);
        o_stat.ch_cr       = (r_ch == tcw_pkg::CH_CR);
        o_stat.scroll_pend = (r_cur_row >= ROW_MAX);
        o_stat.set_blank   = (r_cur_row < ROW_MAX) && (w_set_x < r_cur_col);
        o_stat.rd_ok       = (r_row_in < ROW_MAX) && (r_col_in < COL_MAX);
        o_stat.fill_last   = (r_addr == r_end - tcw_pkg::CNT_W'(1));
        o_stat.copy_done   = (r_addr == COPY_LIM) && !r_cp_vld;
        o_stat.out_free    = w_out_free;
    end

    // Memory write port: blanking, scroll copy or a character store.
    always_comb begin
        w_we = 1'b0;
        w_wa = r_addr[tcw_pkg::ADDR_W-1:0];
        w_wd = tcw_pkg::CH_BLANK;
        if (i_cmd.fill_step) begin
            w_we = 1'b1;
        end else if (i_cmd.copy_step && r_cp_vld) begin
            w_we = 1'b1;
            w_wa = r_cp_addr;
            w_wd = r_rd_data;
        end else if (i_cmd.put_wr) begin
            w_we = 1'b1;
            w_wa = w_cur_addr[tcw_pkg::ADDR_W-1:0];
            w_wd = r_ch;
        end
    end

    // Memory read port: scroll source one row below, or the requested cell.
    always_comb begin
        w_re = w_copy_issue || i_cmd.rd_cell;
        w_ra = w_copy_issue ? (r_addr + CNT_COLS) : w_cell_addr;
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_wa] <= w_wd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_re) begin
            r_rd_data <= r_mem[w_ra[tcw_pkg::ADDR_W-1:0]];
        end
    end

    // Next range counter and end mark.
    always_comb begin
        n_addr = r_addr;
        n_end  = r_end;
        case (i_cmd.fill_sel)
            tcw_pkg::FILL_ALL: begin
                n_addr = '0;
                n_end  = CNT_CELLS;
            end
            tcw_pkg::FILL_EOL: begin
                n_addr = w_cur_addr;
                n_end  = w_base + CNT_COLS;
            end
            tcw_pkg::FILL_ROW: begin
                n_addr = w_base;
                n_end  = w_base + CNT_COLS;
            end
            tcw_pkg::FILL_SET: begin
                n_addr = w_base + tcw_pkg::CNT_W'(w_set_x);
                n_end  = w_cur_addr;
            end
            tcw_pkg::FILL_LAST: begin
                n_addr = COPY_LIM;
                n_end  = CNT_CELLS;
            end
            default: begin
                if (i_cmd.copy_start) begin
                    n_addr = '0;
                end else if (i_cmd.fill_step || w_copy_issue) begin
                    n_addr = r_addr + tcw_pkg::CNT_W'(1);
                end
            end
        endcase
    end

    // Next cursor position.
    always_comb begin
        n_cur_col = r_cur_col;
        n_cur_row = r_cur_row;
        case (i_cmd.cur_sel)
            tcw_pkg::CUR_HOME: begin
                n_cur_col = '0;
                n_cur_row = '0;
            end
            tcw_pkg::CUR_LF: begin
                n_cur_col = '0;
                n_cur_row = r_cur_row + tcw_pkg::ROW_W'(1);
            end
            tcw_pkg::CUR_CR: begin
                n_cur_col = '0;
            end
            tcw_pkg::CUR_ADV: begin
                if (r_cur_col == COL_LAST) begin
                    n_cur_col = '0;
                    n_cur_row = r_cur_row + tcw_pkg::ROW_W'(1);
                end else begin
                    n_cur_col = r_cur_col + tcw_pkg::COL_W'(1);
                end
            end
            tcw_pkg::CUR_SET: begin
                n_cur_col = w_set_x;
            end
            tcw_pkg::CUR_SCROLLED: begin
                n_cur_row = ROW_LAST;
            end
            default: begin
                n_cur_col = r_cur_col;
            end
        endcase
    end

    // Control registers: cursor, range counter, copy pipeline, output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_col <= '0;
            r_cur_row <= '0;
            r_addr    <= '0;
            r_end     <= '0;
            r_cp_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_cur_col <= n_cur_col;
            r_cur_row <= n_cur_row;
            r_addr    <= n_addr;
            r_end     <= n_end;
            if (i_cmd.copy_start) begin
                r_cp_vld <= 1'b0;
            end else if (i_cmd.copy_step) begin
                r_cp_vld <= w_copy_issue;
            end
            if (i_cmd.out_load) begin
                r_out_vld <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.cap_in) begin
            r_op     <= i_op;
            r_ch     <= i_char_code;
            r_col_in <= i_column;
            r_row_in <= i_row;
        end
        if (w_copy_issue) begin
            r_cp_addr <= r_addr[tcw_pkg::ADDR_W-1:0];
        end
        if (i_cmd.clr_cell) begin
            r_cell <= '0;
        end else if (i_cmd.cap_cell) begin
            r_cell <= r_rd_data;
        end
        if (i_cmd.out_load) begin
            r_out_col  <= r_cur_col;
            r_out_row  <= r_cur_row;
            r_out_cell <= r_cell;
        end
    end

    assign o_out_valid  = r_out_vld;
    assign o_cursor_col = r_out_col;
    assign o_cursor_row = r_out_row;
    assign o_cell_char  = r_out_cell;

endmodule

### hdl/tcw_ctrl.sv
// Controller state machine of the text console writer.
// Depends on tcw_pkg; drives tcw_datapath through command and status structs.
module tcw_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    input  tcw_pkg::t_stat i_stat,
    output tcw_pkg::t_cmd  o_cmd
);

    localparam logic [3:0] S_BOOT   = 4'd0;
    localparam logic [3:0] S_IDLE   = 4'd1;
    localparam logic [3:0] S_DISP   = 4'd2;
    localparam logic [3:0] S_PUT    = 4'd3;
    localparam logic [3:0] S_SCROLL = 4'd4;
    localparam logic [3:0] S_FILL   = 4'd5;
    localparam logic [3:0] S_READ   = 4'd6;
    localparam logic [3:0] S_DONE   = 4'd7;

    logic [3:0] r_state, n_state;
    logic [3:0] r_ret, n_ret;

    // Next state, return point after a blanking run, and commands.
    always_comb begin
        n_state = r_state;
        n_ret   = r_ret;
        o_cmd   = '0;
        case (r_state)
            S_BOOT: begin
                o_cmd.fill_sel = tcw_pkg::FILL_ALL;
                n_ret          = S_IDLE;
                n_state        = S_FILL;
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.cap_in = 1'b1;
                    n_state      = S_DISP;
                end
            end
            S_DISP: begin
                o_cmd.clr_cell = 1'b1;
                case (i_stat.op)
                    tcw_pkg::OP_PUT: begin
                        if (i_stat.ch_zero) begin
                            n_state = S_DONE;
                        end else if (i_stat.scroll_pend) begin
                            o_cmd.copy_start = 1'b1;
                            n_state          = S_SCROLL;
                        end else begin
                            n_state = S_PUT;
                        end
                    end
                    tcw_pkg::OP_SETCOL: begin
                        o_cmd.cur_sel = tcw_pkg::CUR_SET;
                        if (i_stat.set_blank) begin
                            o_cmd.fill_sel = tcw_pkg::FILL_SET;
                            n_ret          = S_DONE;
                            n_state        = S_FILL;
                        end else begin
                            n_state = S_DONE;
                        end
                    end
                    tcw_pkg::OP_CLEAR: begin
                        o_cmd.fill_sel = tcw_pkg::FILL_ALL;
                        o_cmd.cur_sel  = tcw_pkg::CUR_HOME;
                        n_ret          = S_DONE;
                        n_state        = S_FILL;
                    end
                    tcw_pkg::OP_READ: begin
                        if (i_stat.rd_ok) begin
                            o_cmd.rd_cell = 1'b1;
                            n_state       = S_READ;
                        end else begin
                            n_state = S_DONE;
                        end
                    end
                    default: begin
                        n_state = S_DONE;
                    end
                endcase
            end
            S_PUT: begin
                if (i_stat.ch_lf) begin
                    o_cmd.fill_sel = tcw_pkg::FILL_EOL;
                    o_cmd.cur_sel  = tcw_pkg::CUR_LF;
                    n_ret          = S_DONE;
                    n_state        = S_FILL;
                end else if (i_stat.ch_cr) begin
                    o_cmd.fill_sel = tcw_pkg::FILL_ROW;
                    o_cmd.cur_sel  = tcw_pkg::CUR_CR;
                    n_ret          = S_DONE;
                    n_state        = S_FILL;
                end else begin
                    o_cmd.put_wr  = 1'b1;
                    o_cmd.cur_sel = tcw_pkg::CUR_ADV;
                    n_state       = S_DONE;
                end
            end
            S_SCROLL: begin
                // Rows move up one cell per cycle; then the last row is blanked.
                if (i_stat.copy_done) begin
                    o_cmd.fill_sel = tcw_pkg::FILL_LAST;
                    o_cmd.cur_sel  = tcw_pkg::CUR_SCROLLED;
                    n_ret          = S_PUT;
                    n_state        = S_FILL;
                end else begin
                    o_cmd.copy_step = 1'b1;
                end
            end
            S_FILL: begin
                o_cmd.fill_step = 1'b1;
                if (i_stat.fill_last) begin
                    n_state = r_ret;
                end
            end
            S_READ: begin
                o_cmd.cap_cell = 1'b1;
                n_state        = S_DONE;
            end
            S_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_BOOT;
            r_ret   <= S_IDLE;
        end else begin
            r_state <= n_state;
            r_ret   <= n_ret;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);

endmodule

### hdl/text_console_writer.sv
// Text console writer: items are taken one at a time. The result turns valid as the input
// reopens; a stalled result holds it. Blanking writes one cell per cycle: line feed blanks
// the COLUMNS-col cells to the end of the row, carriage return the COLUMNS cells of the row,
// a set moving left the cells passed over, clear all CELLS (2000) cells; a pending scroll
// first copies every row up by one and then blanks the last row. Reset runs a full clear.
module text_console_writer (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic [tcw_pkg::OP_W-1:0]     i_op,
    input  logic [tcw_pkg::CHAR_W-1:0]   i_char_code,
    input  logic [tcw_pkg::COL_W-1:0]    i_column,
    input  logic [tcw_pkg::ROW_W-1:0]    i_row,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic [tcw_pkg::COL_W-1:0]    o_cursor_col,
    output logic [tcw_pkg::ROW_W-1:0]    o_cursor_row,
    output logic [tcw_pkg::CHAR_W-1:0]   o_cell_char
);

    tcw_pkg::t_cmd  w_cmd;
    tcw_pkg::t_stat w_stat;

    // Sequencing of every operation.
    tcw_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    // Screen memory, cursor and result register.
    tcw_datapath u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_op         (i_op),
        .i_char_code  (i_char_code),
        .i_column     (i_column),
        .i_row        (i_row),
        .i_cmd        (w_cmd),
        .o_stat       (w_stat),
        .i_out_stall  (i_out_stall),
        .o_out_valid  (o_out_valid),
        .o_cursor_col (o_cursor_col),
        .o_cursor_row (o_cursor_row),
        .o_cell_char  (o_cell_char)
    );

endmodule

### hdl/tcw_checker.sv
// Port-level checker of the text console writer and its bind to the top level.
// Depends on tcw_pkg and text_console_writer_assert.svh.
`include "text_console_writer_assert.svh"

module tcw_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_in_valid,
    input logic                         o_in_stall,
    input logic                         o_out_valid,
    input logic                         i_out_stall,
    input logic [tcw_pkg::COL_W-1:0]    o_cursor_col,
    input logic [tcw_pkg::ROW_W-1:0]    o_cursor_row,
    input logic [tcw_pkg::CHAR_W-1:0]   o_cell_char
);

    // The cursor reported in a result always lies on the screen or one row below.
    `TCW_ASSERT(a_cursor_range, i_clk, i_rst_n, o_out_valid |-> ((o_cursor_col < tcw_pkg::COL_W'(tcw_pkg::COLUMNS)) && (o_cursor_row <= tcw_pkg::ROW_W'(tcw_pkg::ROWS))))

    // One item at a time: the block is busy right after taking an item.
    `TCW_ASSERT(a_busy_after_accept, i_clk, i_rst_n, (i_in_valid && !o_in_stall) |=> o_in_stall)

    // A stalled result stays put.
    `TCW_ASSERT(a_out_hold, i_clk, i_rst_n, (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_cursor_col) && $stable(o_cursor_row) && $stable(o_cell_char)))

    // Reset drops the result and starts the clearing pass with input held off.
    `TCW_ASSERT_ALWAYS(a_reset_quiet, i_clk, !i_rst_n |=> (!o_out_valid && o_in_stall))

endmodule

bind text_console_writer tcw_checker u_tcw_checker (.*);
